// ===== rtl/mof_pkg.sv =====
// Package for the median-of-float block: beat types, cell control and
// IEEE ordering helpers. No dependencies.
package mof_pkg;

  localparam int ValueW = 32;
  localparam int CountW = 11;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              is_last;
  } in_beat_t;

  typedef struct packed {
    logic [ValueW-1:0] median;
    logic [CountW-1:0] count;
    logic              overflow;
  } out_beat_t;

  // Control broadcast to every cell of the chain
  typedef struct packed {
    logic ins;    // insert the incoming value
    logic shift;  // move every cell one place toward cell 0
  } cell_ctl_t;

  // Monotone unsigned key: IEEE order with -0 below +0
  function automatic logic [ValueW-1:0] order_key(input logic [ValueW-1:0] bits);
    order_key = bits[ValueW-1] ? ~bits : (bits ^ {1'b1, {(ValueW-1){1'b0}}});
  endfunction

  function automatic logic is_nan(input logic [ValueW-1:0] bits);
    is_nan = (bits[30:23] == 8'hFF) && (bits[22:0] != 23'd0);
  endfunction

endpackage

// ===== rtl/mof_cell.sv =====
// One cell of the insertion chain: holds one kept value.
// Depends on mof_pkg.
module mof_cell
  import mof_pkg::*;
(
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [ValueW-1:0] new_value,
  input  logic              occupied,
  input  logic              at_end,
  input  logic              prev_gt,
  input  logic [ValueW-1:0] prev_value,
  input  logic [ValueW-1:0] next_value,
  output logic [ValueW-1:0] value,
  output logic              gt
);

  // Flag a held value that sorts above the incoming one
  assign gt = occupied && (order_key(value) > order_key(new_value));

  // Take the left neighbor, the new value, or the right neighbor
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      value <= next_value;
    end else if (ctl.ins) begin
      if (prev_gt) begin
        value <= prev_value;
      end else if (gt || at_end) begin
        value <= new_value;
      end
    end
  end

endmodule

// ===== rtl/median_of_float_block_core.sv =====
// Top level of the median-of-float block: chain of mof_cell and control.
// Depends on mof_pkg and mof_cell.
//
// Usage: in_data beats (value, is_last) enter on in_valid/in_ready. Each
// non-NaN value is inserted into a sorted chain of MAX_ITEMS cells as it is
// taken, so within a block one beat is taken every cycle. On the beat with
// is_last set the block stops taking input and shifts the chain toward
// cell 0 by count/2 places, one place a cycle; cell 0 then holds the
// median. The result is loaded into the output register once the shifting
// is done and the output register is free, and input is taken again the
// cycle after the result is loaded.
// out_data (median, count, overflow) is held on out_valid until out_ready;
// the next block may load into the chain while it waits, and a stall only
// holds the block back when a second result is ready to be loaded.
// Reset clears the count, the overflow flag, the state and out_valid; the
// cell contents are not cleared and are never read before being written.
// NaN values are not kept; an empty block gives median 0, count 0.
module median_of_float_block_core
  import mof_pkg::*;
#(
  parameter int MAX_ITEMS = 1024
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam logic [CW-1:0] Full = CW'(MAX_ITEMS);

  localparam logic [1:0] StLoad  = 2'd0;
  localparam logic [1:0] StShift = 2'd1;

  logic [1:0]        state;
  logic [CW-1:0]     cnt;
  logic              drop;
  logic [CW-1:0]     remaining;

  logic [ValueW-1:0] vals [MAX_ITEMS];
  logic              gts  [MAX_ITEMS];
  cell_ctl_t         ctl;

  logic              accept;
  logic              do_ins;
  logic              out_free;
  logic [CW-1:0]     cnt_next;
  logic              drop_next;
  logic [CW+CountW-1:0] cnt_ext;

  assign in_ready  = (state == StLoad);
  assign accept    = in_valid && in_ready;
  assign do_ins    = accept && !is_nan(in_data.value) && (cnt != Full);
  assign cnt_next  = cnt + CW'(do_ins);
  assign drop_next = drop || (accept && !is_nan(in_data.value) && (cnt == Full));
  assign out_free  = !out_valid || out_ready;
  assign ctl.ins   = do_ins;
  assign ctl.shift = (state == StShift) && (remaining != '0);
  assign cnt_ext   = {{CountW{1'b0}}, cnt};

  // Build the chain of cells
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic              prev_gt;
    logic [ValueW-1:0] prev_value;
    logic [ValueW-1:0] next_value;
    if (i == 0) begin : g_first
      assign prev_gt    = 1'b0;
      assign prev_value = '0;
    end else begin : g_mid
      assign prev_gt    = gts[i-1];
      assign prev_value = vals[i-1];
    end
    if (i == MAX_ITEMS - 1) begin : g_last
      assign next_value = '0;
    end else begin : g_next
      assign next_value = vals[i+1];
    end
    mof_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .new_value  (in_data.value),
      .occupied   (CW'(i) < cnt),
      .at_end     (CW'(i) == cnt),
      .prev_gt    (prev_gt),
      .prev_value (prev_value),
      .next_value (next_value),
      .value      (vals[i]),
      .gt         (gts[i])
    );
  end

  // Sequence loading, shifting toward the median and result hand-off
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= StLoad;
      cnt       <= '0;
      drop      <= 1'b0;
      remaining <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        StLoad: begin
          if (accept) begin
            cnt  <= cnt_next;
            drop <= drop_next;
            if (in_data.is_last) begin
              remaining <= cnt_next >> 1;
              state     <= StShift;
            end
          end
        end
        StShift: begin
          if (remaining != '0) begin
            remaining <= remaining - CW'(1);
          end else if (out_free) begin
            out_valid <= 1'b1;
            cnt       <= '0;
            drop      <= 1'b0;
            state     <= StLoad;
          end
        end
        default: state <= StLoad;
      endcase
    end
  end

  // Load the result beat
  always_ff @(posedge clk) begin
    if (state == StShift && remaining == '0 && out_free) begin
      out_data.median   <= (cnt == '0) ? '0 : vals[0];
      out_data.count    <= cnt_ext[CountW-1:0];
      out_data.overflow <= (cnt == '0) ? 1'b0 : drop;
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt <= Full)
    else $error("kept count above capacity");
  a_drop_full: assert property (@(posedge clk) disable iff (rst) drop |-> cnt == Full)
    else $error("overflow flagged with room left");
  a_shift_down: assert property (@(posedge clk) disable iff (rst)
      (state == StShift && remaining != '0) |=> remaining == $past(remaining) - CW'(1))
    else $error("shift counter did not step");
  a_no_load_shift: assert property (@(posedge clk) disable iff (rst)
      state == StShift |-> !ctl.ins)
    else $error("insert during shift");
`endif

endmodule
